/* rtl/core/iatv_pkg.sv */
// Package for the IP address text validator.
// Holds the queued word type, mode codes and limits shared by all modules.
// No dependencies.
package iatv_pkg;

    typedef enum logic {
        MODE_IPV4 = 1'b0,
        MODE_IPV6 = 1'b1
    } mode_t;

    // one classified character word
    typedef struct packed {
        logic       last;
        logic       no_char;
        logic       is_dec;
        logic       is_hexl;
        logic       is_colon;
        logic       is_dot;
        logic [3:0] digit;
    } item_t;

    localparam int unsigned QDEPTH = 2;
    localparam int unsigned QPTR_W = 1;
    localparam int unsigned QCNT_W = 2;

    localparam logic [7:0] CHAR_COLON = 8'h3A;
    localparam logic [7:0] CHAR_DOT   = 8'h2E;

    localparam logic [9:0] GV_SAT     = 10'd1023;
    localparam logic [9:0] V4_MAX     = 10'd255;
    localparam logic [3:0] V4_GROUPS  = 4'd4;
    localparam logic [3:0] V4_MIN_GRP = 4'd3;
    localparam logic [3:0] V6_GROUPS  = 4'd8;
    localparam logic [3:0] V4_DIGITS  = 4'd3;
    localparam logic [3:0] V6_DIGITS  = 4'd4;

endpackage

/* rtl/core/iatv_front.sv */
// Front end: takes input words and classifies each character.
// Pushes classified words into the queue. Depends on iatv_pkg.
module iatv_front (
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [7:0]          s_tdata,
    input  logic                s_tlast,
    input  logic                s_tuser,
    input  logic                q_full,
    output logic                q_push,
    output iatv_pkg::item_t     q_item
);
    import iatv_pkg::*;

    assign s_tready = !q_full;
    assign q_push   = s_tvalid && !q_full;

    always_comb begin
        q_item          = '0;
        q_item.last     = s_tlast;
        q_item.no_char  = s_tuser;
        q_item.is_dec   = s_tdata inside {[8'h30:8'h39]};
        q_item.is_hexl  = s_tdata inside {[8'h41:8'h46], [8'h61:8'h66]};
        q_item.is_colon = (s_tdata == CHAR_COLON);
        q_item.is_dot   = (s_tdata == CHAR_DOT);
        q_item.digit    = s_tdata[3:0];
    end

endmodule

/* rtl/core/iatv_queue.sv */
// Two-entry queue of classified words between front and back.
// Depends on iatv_pkg.
module iatv_queue (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                push,
    input  iatv_pkg::item_t     push_item,
    output logic                full,
    input  logic                pop,
    output logic                head_valid,
    output iatv_pkg::item_t     head_item
);
    import iatv_pkg::*;

    item_t              mem_reg [QDEPTH];
    logic [QPTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0]  cnt_reg, cnt_next;

    assign full       = (cnt_reg == QCNT_W'(QDEPTH));
    assign head_valid = (cnt_reg != '0);
    assign head_item  = mem_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push && !pop) begin
            cnt_next = cnt_reg + 1'b1;
        end else if (pop && !push) begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_item;
        end
    end

    a_cnt_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= QCNT_W'(QDEPTH))
        else $error("queue count over depth");
    a_no_under: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |-> head_valid)
        else $error("pop from empty queue");
    a_no_over: assert property (@(posedge aclk) disable iff (!aresetn)
        push |-> !full)
        else $error("push into full queue");
    a_ptr_gap: assert property (@(posedge aclk) disable iff (!aresetn)
        (cnt_reg == '0 || cnt_reg == QCNT_W'(QDEPTH)) |-> wr_ptr_reg == rd_ptr_reg)
        else $error("queue pointers inconsistent with count");

endmodule

/* rtl/core/iatv_back.sv */
// Back end: string state update per word, verdict on the last word.
// Holds the mode register and the output register. Depends on iatv_pkg.
module iatv_back (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                cfg_wr_en,
    input  logic                cfg_wr_data,
    input  logic                head_valid,
    input  iatv_pkg::item_t     head_item,
    output logic                pop,
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic                m_res
);
    import iatv_pkg::*;

    mode_t       mode_reg, mode_next;
    logic [3:0]  gc_reg, gc_next;
    logic [2:0]  gd_reg, gd_next;
    logic [9:0]  gv_reg, gv_next;
    logic        prev_reg, prev_next;
    logic        bps_reg, bps_next;
    logic        seen_reg, seen_next;
    logic        first_reg, first_next;
    logic        need_reg, need_next;
    logic        rej_reg, rej_next;
    logic        mv_reg, mv_next;
    logic        res_reg, res_next;

    logic        v6;
    logic        is_sep;
    logic        is_digit;
    logic [3:0]  limit;
    logic [3:0]  nd;
    logic [3:0]  gc_inc;
    logic [13:0] gv_acc;
    logic [3:0]  cnt;
    logic        verdict;

    assign pop      = head_valid && (!mv_reg || m_tready);
    assign m_tvalid = mv_reg;
    assign m_res    = res_reg;

    assign v6       = (mode_reg == MODE_IPV6);
    assign is_sep   = v6 ? head_item.is_colon : head_item.is_dot;
    assign is_digit = head_item.is_dec || (v6 && head_item.is_hexl);
    assign limit    = v6 ? V6_DIGITS : V4_DIGITS;
    assign nd       = {1'b0, gd_reg} + 4'd1;
    assign gc_inc   = gc_reg + 4'd1;
    assign gv_acc   = {1'b0, gv_reg, 3'b000} + {3'b000, gv_reg, 1'b0}
                    + {10'd0, head_item.digit};

    // character step
    always_comb begin
        gc_next    = gc_reg;
        gd_next    = gd_reg;
        gv_next    = gv_reg;
        prev_next  = prev_reg;
        bps_next   = bps_reg;
        seen_next  = seen_reg;
        first_next = first_reg;
        need_next  = need_reg;
        rej_next   = rej_reg;
        if (pop && !head_item.no_char && !rej_reg) begin
            if (need_reg && !is_sep) begin
                need_next = 1'b0;
                rej_next  = 1'b1;
            end else begin
                need_next  = 1'b0;
                bps_next   = first_reg ? 1'b0 : prev_reg;
                first_next = 1'b0;
                if (is_digit) begin
                    prev_next = 1'b0;
                    if (nd > limit) begin
                        rej_next = 1'b1;
                    end else begin
                        gd_next = nd[2:0];
                        if (!v6) begin
                            gv_next = (gv_acc > 14'(GV_SAT)) ? GV_SAT : gv_acc[9:0];
                        end
                    end
                end else if (is_sep && !prev_reg) begin
                    if (first_reg) begin
                        need_next = 1'b1;
                        gc_next   = 4'd1;
                        prev_next = 1'b1;
                    end else if ((!v6 && gc_inc > V4_GROUPS) || (v6 && gc_inc > V6_GROUPS)
                                 || (!v6 && gv_reg > V4_MAX)) begin
                        gc_next  = gc_inc;
                        rej_next = 1'b1;
                    end else begin
                        gc_next   = gc_inc;
                        gv_next   = '0;
                        gd_next   = '0;
                        prev_next = 1'b1;
                    end
                end else if (is_sep && prev_reg && !seen_reg && v6) begin
                    seen_next = 1'b1;
                end else begin
                    rej_next = 1'b1;
                end
            end
        end
    end

    // verdict on the updated state
    always_comb begin
        cnt     = gc_next - ((gd_next == '0) ? 4'd1 : 4'd0);
        verdict = 1'b1;
        if (rej_next || need_next) begin
            verdict = 1'b0;
        end else if (prev_next && (!v6 || !bps_next)) begin
            verdict = 1'b0;
        end else if (!v6 && gv_next > V4_MAX) begin
            verdict = 1'b0;
        end else if (!v6 && cnt < V4_MIN_GRP) begin
            verdict = 1'b0;
        end else if (v6 && cnt < V6_GROUPS && (!seen_next || cnt == '0)) begin
            verdict = 1'b0;
        end
    end

    always_comb begin
        mv_next  = mv_reg;
        res_next = res_reg;
        if (pop && head_item.last) begin
            mv_next  = 1'b1;
            res_next = verdict;
        end else if (m_tready) begin
            mv_next = 1'b0;
        end
    end

    assign mode_next = cfg_wr_en ? mode_t'(cfg_wr_data) : mode_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg  <= MODE_IPV4;
            gc_reg    <= 4'd1;
            gd_reg    <= '0;
            gv_reg    <= '0;
            prev_reg  <= 1'b1;
            bps_reg   <= 1'b0;
            seen_reg  <= 1'b0;
            first_reg <= 1'b1;
            need_reg  <= 1'b0;
            rej_reg   <= 1'b0;
            mv_reg    <= 1'b0;
        end else begin
            mode_reg <= mode_next;
            mv_reg   <= mv_next;
            if (pop && head_item.last) begin
                gc_reg    <= 4'd1;
                gd_reg    <= '0;
                gv_reg    <= '0;
                prev_reg  <= (mode_reg == MODE_IPV4);
                bps_reg   <= 1'b0;
                seen_reg  <= 1'b0;
                first_reg <= 1'b1;
                need_reg  <= 1'b0;
                rej_reg   <= 1'b0;
            end else begin
                gc_reg    <= gc_next;
                gd_reg    <= gd_next;
                gv_reg    <= gv_next;
                prev_reg  <= (cfg_wr_en && first_reg) ? !cfg_wr_data : prev_next;
                bps_reg   <= bps_next;
                seen_reg  <= seen_next;
                first_reg <= first_next;
                need_reg  <= need_next;
                rej_reg   <= rej_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        res_reg <= res_next;
    end

    a_res_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (mv_reg && !m_tready) |=> (mv_reg && $stable(res_reg)))
        else $error("result lost while stalled");
    a_first_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        first_reg |-> (gc_reg == 4'd1 && gd_reg == '0 && !rej_reg && !seen_reg))
        else $error("string state not clean at first character");
    a_digits: assert property (@(posedge aclk) disable iff (!aresetn)
        gd_reg <= 3'(V6_DIGITS))
        else $error("group digit count out of range");
    a_need_pos: assert property (@(posedge aclk) disable iff (!aresetn)
        need_reg |-> (prev_reg && !first_reg))
        else $error("second colon pending outside leading position");

endmodule

/* rtl/core/ip_address_text_validator.sv */
// Top level of the IP address text validator: front, queue and back.
// Depends on iatv_pkg, iatv_front, iatv_queue, iatv_back.
//
//  port group | dir | contents
//  s_*        | in  | one character word: tdata=ch, tuser=no_char, tlast=last
//  m_*        | out | one verdict word per string, on the word marked last
//  cfg_wr_*   | in  | mode register: 0 IPv4 dotted decimal, 1 IPv6 colon hex
//
// One word per cycle unless the output stalls; a word passes from the queue
// through the state update to the output register. The two-entry queue lets
// input run on while the output stalls; backpressure reaches s_tready once full.
// Reset is synchronous, active low, and clears the mode to IPv4.
module ip_address_text_validator (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic        cfg_wr_data,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] ch
    input  logic        s_tlast,
    input  logic        s_tuser,   // [0] no_char
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata    // [0] valid_res, [7:1] zero
);
    import iatv_pkg::*;

    item_t push_item;
    item_t head_item;
    logic  q_full;
    logic  q_push;
    logic  q_pop;
    logic  head_valid;
    logic  res;

    iatv_front u_front (
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .s_tuser  (s_tuser),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_item   (push_item)
    );

    iatv_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (q_push),
        .push_item  (push_item),
        .full       (q_full),
        .pop        (q_pop),
        .head_valid (head_valid),
        .head_item  (head_item)
    );

    iatv_back u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .head_valid  (head_valid),
        .head_item   (head_item),
        .pop         (q_pop),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_res       (res)
    );

    assign m_tdata = {7'd0, res};

endmodule

/* tb/tb_ip_address_text_validator.sv */
// Self-checking bench for ip_address_text_validator: directed and random address strings.
// Verdicts are predicted at input acceptance and checked in order on the m_ side.
// Depends on iatv_pkg and the validator RTL.
module tb_ip_address_text_validator;
    import iatv_pkg::*;

    localparam int QUIET_LIMIT  = 2000;
    localparam int DRAIN_CYCLES = 8;
    localparam int N_RANDOM     = 850;
    localparam logic [7:0] CH_ZERO = 8'h30;
    localparam logic [7:0] CH_LA   = 8'h61;
    localparam logic [7:0] CH_UA   = 8'h41;

    typedef struct packed {
        logic [7:0] ch;
        logic       no_char;
        logic       last;
    } char_word_t;

    logic       aclk = 1'b0;
    logic       aresetn = 1'b0;
    logic       cfg_wr_en = 1'b0;
    logic       cfg_wr_data = 1'b0;
    logic       s_tvalid = 1'b0;
    logic       s_tready;
    logic [7:0] s_tdata = 8'h00;   // [7:0] ch
    logic       s_tlast = 1'b0;
    logic       s_tuser = 1'b0;    // [0] no_char
    logic       m_tvalid;
    logic       m_tready = 1'b0;
    logic [7:0] m_tdata;           // [0] valid_res, [7:1] zero

    ip_address_text_validator dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tlast     (s_tlast),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    char_word_t pending[$];
    bit         verdict_q[$];
    logic [7:0] txt[$];
    int         items_made = 0;
    int         gap_pct = 7;
    int         errors = 0;
    int         verdicts_seen = 0;
    int         hold_left = 0;
    bit         held = 1'b0;
    int         quiet = 0;
    char_word_t nxt;
    bit         want_verdict;

    // address checker state
    mode_t       cur_mode;
    logic [3:0]  grp_cnt;
    logic [2:0]  grp_digits;
    logic [9:0]  grp_val;
    logic        sep_last;
    logic        sep_before;
    logic        got_dbl;
    logic        at_start;
    logic        want_colon;
    logic        failed;

    function automatic void clear_addr();
        grp_cnt    = 4'd1;
        grp_digits = 3'd0;
        grp_val    = 10'd0;
        sep_last   = (cur_mode == MODE_IPV4);
        sep_before = 1'b0;
        got_dbl    = 1'b0;
        at_start   = 1'b1;
        want_colon = 1'b0;
        failed     = 1'b0;
    endfunction

    function automatic void set_mode(input mode_t m);
        cur_mode = m;
        if (at_start)
            sep_last = (m == MODE_IPV4);
    endfunction

    function automatic void feed_char(input logic [7:0] c);
        logic [7:0] sep_ch;
        logic       is_dec;
        logic       is_hex;
        logic       prev;
        logic       first;
        int         nd;
        int         lim;
        int         v;
        sep_ch = (cur_mode == MODE_IPV6) ? CHAR_COLON : CHAR_DOT;
        is_dec = c >= "0" && c <= "9";
        is_hex = cur_mode == MODE_IPV6 &&
                 ((c >= "a" && c <= "f") || (c >= "A" && c <= "F"));
        prev = sep_last;
        first = at_start;
        if (want_colon) begin
            want_colon = 1'b0;
            if (c != sep_ch) begin
                failed = 1'b1;
                return;
            end
        end
        sep_before = first ? 1'b0 : prev;
        at_start = 1'b0;
        if (is_dec || is_hex) begin
            lim = (cur_mode == MODE_IPV6) ? V6_DIGITS : V4_DIGITS;
            nd = grp_digits + 1;
            sep_last = 1'b0;
            if (nd > lim) begin
                failed = 1'b1;
                return;
            end
            grp_digits = nd[2:0];
            if (cur_mode == MODE_IPV4) begin
                v = grp_val * 10 + (c - CH_ZERO);
                grp_val = (v > GV_SAT) ? GV_SAT : v[9:0];
            end
        end else if (c == sep_ch && !prev) begin
            if (first) begin
                // leading colon: only "::" may follow
                want_colon = 1'b1;
                grp_cnt = 4'd1;
                sep_last = 1'b1;
                return;
            end
            grp_cnt = grp_cnt + 4'd1;
            if ((cur_mode == MODE_IPV4 && grp_cnt > V4_GROUPS) ||
                (cur_mode == MODE_IPV6 && grp_cnt > V6_GROUPS) ||
                (cur_mode == MODE_IPV4 && grp_val > V4_MAX)) begin
                failed = 1'b1;
                return;
            end
            grp_val = 10'd0;
            grp_digits = 3'd0;
            sep_last = 1'b1;
        end else if (c == sep_ch && prev && !got_dbl && cur_mode == MODE_IPV6) begin
            got_dbl = 1'b1;
        end else begin
            failed = 1'b1;
        end
    endfunction

    function automatic logic addr_ok();
        int n;
        if (failed || want_colon)
            return 1'b0;
        if (sep_last && (cur_mode == MODE_IPV4 || !sep_before))
            return 1'b0;
        if (cur_mode == MODE_IPV4 && grp_val > V4_MAX)
            return 1'b0;
        n = grp_cnt;
        if (grp_digits == 0)
            n = n - 1;
        if (cur_mode == MODE_IPV4 && n < int'(V4_MIN_GRP))
            return 1'b0;
        if (cur_mode == MODE_IPV6 && n < int'(V6_GROUPS) && (!got_dbl || n == 0))
            return 1'b0;
        return 1'b1;
    endfunction

    function automatic void take_word(input char_word_t w);
        if (!w.no_char && !failed)
            feed_char(w.ch);
        if (w.last) begin
            verdict_q.push_back(addr_ok());
            clear_addr();
        end
    endfunction

    // stimulus helpers
    task automatic push_word(input logic [7:0] c, input logic nc, input logic lst);
        pending.push_back('{ch: c, no_char: nc, last: lst});
        if (!nc || lst)
            items_made++;
    endtask

    task automatic push_text(input string s, input bit close);
        int i;
        for (i = 0; i < s.len(); i++)
            push_word(s[i], 1'b0, close && i == s.len() - 1);
    endtask

    function automatic logic [7:0] pick_char();
        logic [7:0] r;
        case ($urandom_range(0, 6))
            0: begin r = 8'($urandom_range(0, 9)); return CH_ZERO + r; end
            1: begin r = 8'($urandom_range(0, 7)); return CH_LA + r; end
            2: begin r = 8'($urandom_range(0, 7)); return CH_UA + r; end
            3: return CHAR_DOT;
            4: return CHAR_COLON;
            5: return $urandom_range(0, 1) ? 8'h00 : 8'hFF;
            default: begin r = 8'($urandom_range(0, 255)); return r; end
        endcase
    endfunction

    task automatic add_hex(input int nd);
        logic [7:0] d;
        repeat (nd) begin
            d = 8'($urandom_range(0, 15));
            if (d < 10)
                txt.push_back(CH_ZERO + d);
            else
                txt.push_back(($urandom_range(0, 1) ? CH_UA : CH_LA) + d - 8'd10);
        end
    endtask

    task automatic make_text(input mode_t m);
        int         n;
        int         k;
        int         v;
        int         pad;
        int         left;
        int         j;
        bit         dbl;
        logic [7:0] dg;
        txt.delete();
        if ($urandom_range(0, 99) < 10) begin
            n = $urandom_range(0, 8);
            repeat (n) txt.push_back(pick_char());
            return;
        end
        if (($urandom_range(0, 99) < 85) == (m == MODE_IPV4)) begin
            n = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 5) : $urandom_range(3, 4);
            for (k = 0; k < n; k++) begin
                if (k != 0)
                    txt.push_back(CHAR_DOT);
                v = ($urandom_range(0, 9) == 0) ? $urandom_range(256, 999) :
                                                  $urandom_range(0, 255);
                pad = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 4) : 0;
                if (pad == 4)
                    txt.push_back(CH_ZERO);
                if (v >= 100 || pad >= 3) begin
                    dg = 8'(v / 100);
                    txt.push_back(CH_ZERO + dg);
                end
                if (v >= 10 || pad >= 2) begin
                    dg = 8'((v / 10) % 10);
                    txt.push_back(CH_ZERO + dg);
                end
                dg = 8'(v % 10);
                txt.push_back(CH_ZERO + dg);
            end
        end else begin
            dbl = ($urandom_range(0, 1) != 0);
            if (dbl)
                n = $urandom_range(0, 8);
            else
                n = ($urandom_range(0, 9) == 0) ? $urandom_range(6, 9) : 8;
            left = dbl ? $urandom_range(0, n) : n;
            for (k = 0; k < left; k++) begin
                if (k != 0)
                    txt.push_back(CHAR_COLON);
                add_hex(($urandom_range(0, 19) == 0) ? 5 : $urandom_range(1, 4));
            end
            if (dbl) begin
                txt.push_back(CHAR_COLON);
                txt.push_back(CHAR_COLON);
                for (k = 0; k < n - left; k++) begin
                    if (k != 0)
                        txt.push_back(CHAR_COLON);
                    add_hex(($urandom_range(0, 19) == 0) ? 5 : $urandom_range(1, 4));
                end
            end
        end
        if (txt.size() != 0 && $urandom_range(0, 3) == 0) begin
            j = $urandom_range(0, txt.size() - 1);
            case ($urandom_range(0, 2))
                0: txt[j] = pick_char();
                1: txt.delete(j);
                default: txt.insert(j, pick_char());
            endcase
        end
    endtask

    task automatic put_string(input bit close);
        bit split_end;
        split_end = (txt.size() == 0) || ($urandom_range(0, 4) == 0);
        foreach (txt[k]) begin
            if ($urandom_range(0, 19) == 0)
                push_word(8'($urandom_range(0, 255)), 1'b1, 1'b0);
            push_word(txt[k], 1'b0, close && !split_end && k == txt.size() - 1);
        end
        if (close && split_end)
            push_word(8'($urandom_range(0, 255)), 1'b1, 1'b1);
    endtask

    task automatic wait_idle();
        do begin
            while (pending.size() != 0 || s_tvalid || verdict_q.size() != 0)
                @(posedge aclk);
            repeat (DRAIN_CYCLES) @(posedge aclk);
        end while (pending.size() != 0 || s_tvalid || verdict_q.size() != 0);
    endtask

    task automatic write_mode(input mode_t m);
        @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= m;
        set_mode(m);
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    // driver
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready)
                take_word({s_tdata, s_tuser, s_tlast});
            if (!s_tvalid || s_tready) begin
                if (pending.size() != 0 && $urandom_range(0, 99) >= gap_pct) begin
                    nxt = pending.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata <= nxt.ch;
                    s_tuser <= nxt.no_char;
                    s_tlast <= nxt.last;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // monitor
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (verdict_q.size() == 0) begin
                    errors++;
                    $display("%0t: unexpected verdict word, expected none, got %h",
                             $time, m_tdata);
                end else begin
                    want_verdict = verdict_q.pop_front();
                    if (m_tdata !== {7'd0, want_verdict}) begin
                        errors++;
                        $display("%0t: verdict mismatch, expected %h, got %h",
                                 $time, {7'd0, want_verdict}, m_tdata);
                    end
                end
                verdicts_seen++;
            end
            // one long hold-off while the sender keeps going
            if (!held && verdicts_seen >= 20 && pending.size() > 20) begin
                held = 1'b1;
                hold_left = 150;
            end
            if (hold_left != 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= ($urandom_range(0, 99) >= gap_pct);
            end
        end
    end

    // watchdog
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet <= 0;
        end else if (quiet == QUIET_LIMIT) begin
            $display("ip_address_text_validator regression: fail");
            $finish;
        end else begin
            quiet <= quiet + 1;
        end
    end

    initial begin
        int    ph;
        int    nstr;
        mode_t m;
        cur_mode = MODE_IPV4;
        clear_addr();
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        write_mode(MODE_IPV4);
        push_word(8'hFF, 1'b1, 1'b1);       // empty string
        push_text("1.2.3", 1'b1);           // three groups
        push_text("9", 1'b0);
        push_word(8'hFF, 1'b1, 1'b0);       // ignored word
        push_word(8'h00, 1'b0, 1'b1);       // NUL
        push_text("7.", 1'b1);              // trailing dot
        push_text("1", 1'b0);               // string left open across mode change
        wait_idle();
        write_mode(MODE_IPV6);
        push_text(":", 1'b1);
        push_text("::", 1'b1);
        push_text("a:B:c:D:e:F:0::9", 1'b1);
        wait_idle();
        write_mode(MODE_IPV4);

        items_made = 0;
        ph = 0;
        m = MODE_IPV4;
        while (items_made < N_RANDOM) begin
            gap_pct = (ph == 2) ? 0 : 7;
            nstr = $urandom_range(5, 12);
            repeat (nstr) begin
                make_text(m);
                put_string(1'b1);
            end
            if ($urandom_range(0, 3) == 0) begin
                make_text(m);
                put_string(1'b0);
            end
            wait_idle();
            m = $urandom_range(0, 1) ? MODE_IPV6 : MODE_IPV4;
            write_mode(m);
            ph++;
        end
        make_text(m);
        put_string(1'b1);
        wait_idle();

        if (errors == 0)
            $display("ip_address_text_validator regression: pass");
        else
            $display("ip_address_text_validator regression: fail");
        $finish;
    end

endmodule
